// ----- sv/fgwi_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the keypoint grid index.
// No dependencies; used by the channel interfaces and the top level.
package fgwi_pkg;

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;

   localparam logic [7:0] CSR_ORIGIN_X = 8'd0;
   localparam logic [7:0] CSR_ORIGIN_Y = 8'd1;
   localparam logic [7:0] CSR_SCALE_X  = 8'd2;
   localparam logic [7:0] CSR_SCALE_Y  = 8'd3;

   localparam int KEY_W  = 10;
   localparam int CELL_W = 6;
   localparam int FRAC_W = 20;

   typedef struct packed {
      logic [1:0]        req_type;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [2:0]        octave;
      logic [KEY_W-1:0]  key_index;
      logic [14:0]       radius;
      logic signed [3:0] min_level;
      logic signed [3:0] max_level;
   } req_word_type;

   typedef struct packed {
      logic [KEY_W-1:0]  match_index;
      logic              found;
      logic              last;
      logic              overflow;
      logic              dropped;
      logic [CELL_W-1:0] cell_col;
      logic [CELL_W-1:0] cell_row;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]  index;
      logic [15:0] data;
   } csr_word_type;

   typedef enum logic [3:0] {
      ST_CLR, ST_CLR_RSP, ST_IDLE,
      ST_IMUL, ST_IBIN, ST_IRD, ST_IUPD,
      ST_QMUL, ST_QRNG, ST_QCELL, ST_QMEM, ST_QKEY, ST_QTEST, ST_QEND
   } state_type;

endpackage

// ----- sv/fgwi_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on fgwi_pkg for the payload types.
interface fgwi_req_if;
   logic                  valid;
   logic                  ready;
   fgwi_pkg::req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface fgwi_rsp_if;
   logic                  valid;
   logic                  ready;
   fgwi_pkg::rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface fgwi_csr_if;
   logic                  valid;
   logic                  ready;
   fgwi_pkg::csr_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/feature_grid_window_index.sv -----
`timescale 1ns / 1ps
// Uniform grid index of keypoints with insert, clear and window query.
// Depends on fgwi_pkg and the channel interfaces in fgwi_if.sv.
//
//   channel    dir  word
//   req_if     in   req_type, pos, octave, key_index, radius, level bounds
//   rsp_if     out  match_index, found, last, overflow, dropped, cell
//   csr_if     in   register index, 16 bit data
//
// Insert: scale the position, bin it to a cell, read that cell's fill count,
// then add the key if the cell has room and send the result word. Clear:
// clears the fill memory, GRID_COLS*GRID_ROWS cells (3072 by default), one
// cell a cycle, then the result word. Query: a fill-count read per cell in
// the window, and per member visited a member-memory read then a key-memory read.
// After reset the same clearing pass runs before the first request is taken.
// A stalled result channel holds the walk at the next word to be sent.
module feature_grid_window_index #(
   parameter int GRID_COLS   = 64,
   parameter int GRID_ROWS   = 48,
   parameter int MAX_KEYS    = 1024,
   parameter int CELL_CAP    = 16,
   parameter int MAX_MATCHES = 64
) (
   input logic          clock,
   input logic          reset,
   fgwi_req_if.sink     req_if,
   fgwi_rsp_if.source   rsp_if,
   fgwi_csr_if.sink     csr_if
);

   localparam int CELLS   = GRID_COLS * GRID_ROWS;
   localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int MEM_AW  = (CELLS * CELL_CAP > 1) ? $clog2(CELLS * CELL_CAP) : 1;
   localparam int KEY_AW  = $clog2(MAX_KEYS);
   localparam int FILL_W  = $clog2(CELL_CAP + 1);
   localparam int COL_W   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int ROW_W   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int CNT_W   = $clog2(MAX_MATCHES + 1);
   localparam int KW      = fgwi_pkg::KEY_W;

   fgwi_pkg::state_type state_ff, state_in;

   logic signed [15:0] origin_x_ff, origin_y_ff;
   logic [15:0]        scale_x_ff, scale_y_ff;
   fgwi_pkg::req_word_type req_ff;

   logic signed [35:0] px_lo_ff, px_hi_ff, py_lo_ff, py_hi_ff;
   logic [CELL_AW-1:0] clr_addr_ff, cell_ff;
   logic               clr_rsp_ff;
   logic               ins_ok_ff;
   logic [5:0]         ins_col_ff, ins_row_ff;
   logic [COL_W-1:0]   ix_ff, cend_ff;
   logic [ROW_W-1:0]   iy_ff, rstart_ff, rend_ff;
   logic [FILL_W-1:0]  j_ff;
   logic [CNT_W-1:0]   n_ff;
   logic               pend_ff;
   logic [KW-1:0]      pend_idx_ff;

   // memories
   logic [FILL_W-1:0]  fill_mem [CELLS];
   logic [KW-1:0]      member_mem [CELLS * CELL_CAP];
   logic [34:0]        key_mem [MAX_KEYS];
   logic [FILL_W-1:0]  fill_rd_ff;
   logic [KW-1:0]      member_rd_ff;
   logic [34:0]        key_rd_ff;

   logic               fill_re, fill_we, member_we, key_we, key_re, member_re;
   logic [CELL_AW-1:0] fill_addr;
   logic [FILL_W-1:0]  fill_wd;
   logic [MEM_AW-1:0]  member_addr;
   logic [KEY_AW-1:0]  key_waddr, key_raddr;

   logic               out_free, emit;
   fgwi_pkg::rsp_word_type emit_data, rsp_ff;
   logic               rsp_valid_ff;

   // ---------------- configuration
   assign csr_if.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         scale_x_ff  <= 16'd6554;
         scale_y_ff  <= 16'd6554;
      end else if (csr_if.valid) begin
         unique case (csr_if.data.index)
            fgwi_pkg::CSR_ORIGIN_X: origin_x_ff <= csr_if.data.data;
            fgwi_pkg::CSR_ORIGIN_Y: origin_y_ff <= csr_if.data.data;
            fgwi_pkg::CSR_SCALE_X:  scale_x_ff  <= csr_if.data.data;
            fgwi_pkg::CSR_SCALE_Y:  scale_y_ff  <= csr_if.data.data;
            default: ;
         endcase
      end
   end

   // ---------------- arithmetic
   logic signed [17:0] dx_lo, dx_hi, dy_lo, dy_hi, rad_s;
   logic signed [16:0] sx_s, sy_s;
   assign rad_s = $signed({3'b000, req_ff.radius});
   assign sx_s  = $signed({1'b0, scale_x_ff});
   assign sy_s  = $signed({1'b0, scale_y_ff});

   always_comb begin
      dx_lo = 18'(req_ff.pos_x) - 18'(origin_x_ff);
      dy_lo = 18'(req_ff.pos_y) - 18'(origin_y_ff);
      dx_hi = dx_lo + rad_s;
      dy_hi = dy_lo + rad_s;
      if (state_ff == fgwi_pkg::ST_QMUL) begin
         dx_lo = dx_lo - rad_s;
         dy_lo = dy_lo - rad_s;
      end
   end

   // round half away from zero, Q.20 to integer
   function automatic logic signed [17:0] round_q(input logic signed [35:0] v);
      logic [35:0] mag;
      logic [35:0] sum;
      logic [17:0] q;
      mag = v[35] ? 36'(-v) : 36'(v);
      sum = mag + 36'(1 << (fgwi_pkg::FRAC_W - 1));
      q   = 18'(sum[35:fgwi_pkg::FRAC_W]);
      return v[35] ? $signed(-q) : $signed(q);
   endfunction

   logic signed [17:0] rnd_col, rnd_row, fl_col, ce_col, fl_row, ce_row;
   logic signed [17:0] c0, c1, r0, r1;
   logic               ins_in_grid, key_ok;
   assign rnd_col = round_q(px_lo_ff);
   assign rnd_row = round_q(py_lo_ff);
   assign ins_in_grid = !rnd_col[17] && (rnd_col < 18'(GRID_COLS))
                        && !rnd_row[17] && (rnd_row < 18'(GRID_ROWS));
   assign key_ok = {1'b0, req_ff.key_index} < 17'(MAX_KEYS);

   assign fl_col = 18'(px_lo_ff >>> fgwi_pkg::FRAC_W);
   assign fl_row = 18'(py_lo_ff >>> fgwi_pkg::FRAC_W);
   assign ce_col = 18'((px_hi_ff + 36'((1 << fgwi_pkg::FRAC_W) - 1)) >>> fgwi_pkg::FRAC_W);
   assign ce_row = 18'((py_hi_ff + 36'((1 << fgwi_pkg::FRAC_W) - 1)) >>> fgwi_pkg::FRAC_W);
   assign c0 = fl_col[17] ? 18'sd0 : fl_col;
   assign r0 = fl_row[17] ? 18'sd0 : fl_row;
   assign c1 = (ce_col > 18'(GRID_COLS - 1)) ? 18'(GRID_COLS - 1) : ce_col;
   assign r1 = (ce_row > 18'(GRID_ROWS - 1)) ? 18'(GRID_ROWS - 1) : ce_row;

   logic range_empty;
   assign range_empty = (c0 > c1) || (r0 > r1);

   // member test
   logic signed [16:0] ddx, ddy;
   logic [16:0]        adx, ady;
   logic signed [4:0]  ko, minl, maxl;
   logic               lvl_ok, hit;
   always_comb begin
      ddx  = 17'(signed'(key_rd_ff[15:0])) - 17'(req_ff.pos_x);
      ddy  = 17'(signed'(key_rd_ff[31:16])) - 17'(req_ff.pos_y);
      adx  = ddx[16] ? 17'(-ddx) : 17'(ddx);
      ady  = ddy[16] ? 17'(-ddy) : 17'(ddy);
      ko   = $signed({2'b00, key_rd_ff[34:32]});
      minl = 5'(req_ff.min_level);
      maxl = 5'(req_ff.max_level);
      lvl_ok = 1'b1;
      if (minl > 5'sd0 || !maxl[4]) begin
         if (ko < minl) lvl_ok = 1'b0;
         if (!maxl[4] && ko > maxl) lvl_ok = 1'b0;
      end
      hit = lvl_ok && (adx < {2'b00, req_ff.radius}) && (ady < {2'b00, req_ff.radius});
   end

   logic at_cap;
   logic last_member, last_cell;
   assign at_cap      = n_ff == CNT_W'(MAX_MATCHES);
   assign last_member = j_ff == fill_rd_ff;
   assign last_cell   = (ix_ff == cend_ff) && (iy_ff == rend_ff);
   assign out_free    = !rsp_valid_ff || rsp_if.ready;

   // ---------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fgwi_pkg::ST_CLR:
            if (clr_addr_ff == CELL_AW'(CELLS - 1))
               state_in = clr_rsp_ff ? fgwi_pkg::ST_CLR_RSP : fgwi_pkg::ST_IDLE;
         fgwi_pkg::ST_CLR_RSP:
            if (out_free) state_in = fgwi_pkg::ST_IDLE;
         fgwi_pkg::ST_IDLE:
            if (req_if.valid) begin
               case (req_if.data.req_type)
                  fgwi_pkg::REQ_CLEAR:  state_in = fgwi_pkg::ST_CLR;
                  fgwi_pkg::REQ_INSERT: state_in = fgwi_pkg::ST_IMUL;
                  fgwi_pkg::REQ_QUERY:  state_in = fgwi_pkg::ST_QMUL;
                  default:              state_in = fgwi_pkg::ST_IDLE;
               endcase
            end
         fgwi_pkg::ST_IMUL: state_in = fgwi_pkg::ST_IBIN;
         fgwi_pkg::ST_IBIN: state_in = fgwi_pkg::ST_IRD;
         fgwi_pkg::ST_IRD:  state_in = fgwi_pkg::ST_IUPD;
         fgwi_pkg::ST_IUPD:
            if (out_free) state_in = fgwi_pkg::ST_IDLE;
         fgwi_pkg::ST_QMUL: state_in = fgwi_pkg::ST_QRNG;
         fgwi_pkg::ST_QRNG:
            state_in = range_empty ? fgwi_pkg::ST_QEND : fgwi_pkg::ST_QCELL;
         fgwi_pkg::ST_QCELL: state_in = fgwi_pkg::ST_QMEM;
         fgwi_pkg::ST_QMEM:
            if (!last_member)  state_in = fgwi_pkg::ST_QKEY;
            else if (last_cell) state_in = fgwi_pkg::ST_QEND;
            else               state_in = fgwi_pkg::ST_QCELL;
         fgwi_pkg::ST_QKEY: state_in = fgwi_pkg::ST_QTEST;
         fgwi_pkg::ST_QTEST:
            if (!hit) state_in = fgwi_pkg::ST_QMEM;
            else if (!pend_ff || out_free)
               state_in = at_cap ? fgwi_pkg::ST_IDLE : fgwi_pkg::ST_QMEM;
         fgwi_pkg::ST_QEND:
            if (out_free) state_in = fgwi_pkg::ST_IDLE;
         default: state_in = fgwi_pkg::ST_IDLE;
      endcase
   end

   // ---------------- outputs of the controller
   always_comb begin
      fill_re = 1'b0; fill_we = 1'b0; member_we = 1'b0; member_re = 1'b0;
      key_we = 1'b0; key_re = 1'b0;
      fill_addr   = cell_ff;
      fill_wd     = '0;
      member_addr = MEM_AW'(32'(cell_ff) * CELL_CAP + 32'(j_ff));
      key_waddr   = KEY_AW'(req_ff.key_index);
      key_raddr   = KEY_AW'(member_rd_ff);
      emit        = 1'b0;
      emit_data   = '0;
      emit_data.last = 1'b1;
      req_if.ready = state_ff == fgwi_pkg::ST_IDLE;
      unique case (state_ff)
         fgwi_pkg::ST_CLR: begin
            fill_we   = 1'b1;
            fill_addr = clr_addr_ff;
         end
         fgwi_pkg::ST_CLR_RSP: emit = out_free;
         fgwi_pkg::ST_IMUL: key_we = key_ok;
         fgwi_pkg::ST_IRD: fill_re = ins_ok_ff;
         fgwi_pkg::ST_IUPD: begin
            emit = out_free;
            if (!ins_ok_ff) begin
               emit_data.dropped = 1'b1;
            end else begin
               emit_data.cell_col = ins_col_ff;
               emit_data.cell_row = ins_row_ff;
               if (fill_rd_ff >= FILL_W'(CELL_CAP)) begin
                  emit_data.dropped = 1'b1;
               end else begin
                  fill_we     = out_free;
                  fill_wd     = fill_rd_ff + 1'b1;
                  member_we   = out_free;
                  member_addr = MEM_AW'(32'(cell_ff) * CELL_CAP + 32'(fill_rd_ff));
               end
            end
         end
         fgwi_pkg::ST_QCELL: begin
            fill_re   = 1'b1;
            fill_addr = CELL_AW'(32'(ix_ff) * GRID_ROWS + 32'(iy_ff));
         end
         fgwi_pkg::ST_QMEM: member_re = !last_member;
         fgwi_pkg::ST_QKEY: key_re = 1'b1;
         fgwi_pkg::ST_QTEST:
            if (hit && pend_ff) begin
               emit = out_free;
               emit_data.match_index = pend_idx_ff;
               emit_data.found       = 1'b1;
               emit_data.last        = at_cap;
               emit_data.overflow    = at_cap;
            end
         fgwi_pkg::ST_QEND: begin
            emit = out_free;
            emit_data.match_index = pend_ff ? pend_idx_ff : '0;
            emit_data.found       = pend_ff;
         end
         default: ;
      endcase
   end

   // ---------------- memories
   always_ff @(posedge clock) begin
      if (fill_we) fill_mem[fill_addr] <= fill_wd;
      if (fill_re) fill_rd_ff <= fill_mem[fill_addr];
   end

   always_ff @(posedge clock) begin
      if (member_we) member_mem[member_addr] <= req_ff.key_index;
      if (member_re) member_rd_ff <= member_mem[member_addr];
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_waddr] <= {req_ff.octave, req_ff.pos_y, req_ff.pos_x};
      if (key_re) key_rd_ff <= key_mem[key_raddr];
   end

   // ---------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= fgwi_pkg::ST_CLR;
         clr_addr_ff <= '0;
         clr_rsp_ff  <= 1'b0;
         pend_ff     <= 1'b0;
         n_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == fgwi_pkg::ST_CLR)
            clr_addr_ff <= clr_addr_ff + 1'b1;
         if (state_ff == fgwi_pkg::ST_IDLE) begin
            clr_addr_ff <= '0;
            clr_rsp_ff  <= 1'b1;
            pend_ff     <= 1'b0;
            n_ff        <= '0;
         end
         // hold the newest match back so the final word can carry last
         if (state_ff == fgwi_pkg::ST_QTEST && hit && (!pend_ff || out_free) && !at_cap) begin
            pend_ff <= 1'b1;
            n_ff    <= n_ff + 1'b1;
         end
      end
   end

   // ---------------- datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == fgwi_pkg::ST_IDLE && req_if.valid)
         req_ff <= req_if.data;
      if (state_ff == fgwi_pkg::ST_IMUL || state_ff == fgwi_pkg::ST_QMUL) begin
         px_lo_ff <= dx_lo * sx_s;
         py_lo_ff <= dy_lo * sy_s;
         px_hi_ff <= dx_hi * sx_s;
         py_hi_ff <= dy_hi * sy_s;
      end
      if (state_ff == fgwi_pkg::ST_IBIN) begin
         ins_ok_ff  <= key_ok && ins_in_grid;
         ins_col_ff <= 6'(rnd_col);
         ins_row_ff <= 6'(rnd_row);
         cell_ff    <= CELL_AW'(32'(rnd_col[COL_W:0]) * GRID_ROWS + 32'(rnd_row[ROW_W:0]));
      end
      if (state_ff == fgwi_pkg::ST_QRNG) begin
         ix_ff     <= COL_W'(c0);
         cend_ff   <= COL_W'(c1);
         iy_ff     <= ROW_W'(r0);
         rstart_ff <= ROW_W'(r0);
         rend_ff   <= ROW_W'(r1);
      end
      if (state_ff == fgwi_pkg::ST_QCELL) begin
         cell_ff <= CELL_AW'(32'(ix_ff) * GRID_ROWS + 32'(iy_ff));
         j_ff    <= '0;
      end
      // columns outer, rows inner
      if (state_ff == fgwi_pkg::ST_QMEM && last_member && !last_cell) begin
         if (iy_ff == rend_ff) begin
            iy_ff <= rstart_ff;
            ix_ff <= ix_ff + 1'b1;
         end else begin
            iy_ff <= iy_ff + 1'b1;
         end
      end
      if (state_ff == fgwi_pkg::ST_QTEST && state_in == fgwi_pkg::ST_QMEM)
         j_ff <= j_ff + 1'b1;
      if (state_ff == fgwi_pkg::ST_QTEST && hit && (!pend_ff || out_free))
         pend_idx_ff <= member_rd_ff;
   end

   // ---------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) rsp_ff <= emit_data;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_ff;

endmodule
